// ===== hw/rtl/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude core.
`default_nettype none
package sobel_pkg;

	localparam int PIXEL_BITS  = 8;
	localparam int COL_BITS    = 12;
	localparam int ROW_BITS    = 12;
	localparam int HGT_BITS    = 13;
	localparam int OUT_COL_BITS = 11;
	localparam int MAX_HEIGHT  = 4096;
	localparam int GRAD_BITS   = PIXEL_BITS + 2;
	localparam int SQ_BITS     = 2 * GRAD_BITS;
	localparam int SUM_BITS    = SQ_BITS + 1;
	localparam int ROOT_BITS   = (SUM_BITS + 1) / 2;
	localparam int RAD_BITS    = 2 * ROOT_BITS;
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 13;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [COL_BITS-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [HGT_BITS-1:0] HEIGHT_RESET = 13'd480;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef pix_t [8:0] win_t;

	typedef struct packed {
		logic [COL_BITS-1:0] width;
		logic [HGT_BITS-1:0] height;
	} frame_cfg_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]     row;
		logic [OUT_COL_BITS-1:0] col;
		logic                    last;
	} tag_t;

	typedef struct packed {
		win_t win;
		tag_t tag;
	} q_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// Top level of the Sobel 3x3 gradient magnitude core.
//
// Pixels enter in raster order on the input channel (in_valid/in_stall, pixel,
// frame_start); frame_start restarts the row and column counters. For each
// interior pixel a request leaves on the output channel (out_valid/out_stall)
// with floor(sqrt(Gx^2+Gy^2)), the centre row and column, and frame_last on
// the last interior pixel. Border pixels give no request.
// Frame size is set by image_width (index 0) and image_height (index 1)
// through the cfg channel, always ready; write only while the core is idle.
// Throughput: one pixel per clock. The front end stalls only when the
// 4-entry window queue is full, which happens when out_stall has held the
// 14-stage gradient and square root pipeline. From input accept, a pixel
// passes the front-end register, a queue slot and that pipeline to out_valid.
// Reset clears counters, window and queue; line store contents stay
// undefined and no clearing pass runs, so pixels are accepted right away.
// Registers reset to 640 x 480.
`default_nettype none
module sobel_edge_magnitude_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [sobel_pkg::PIXEL_BITS-1:0]       pixel,
	input  wire logic                                   frame_start,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [sobel_pkg::ROOT_BITS-1:0]             magnitude,
	output logic [sobel_pkg::ROW_BITS-1:0]              out_row,
	output logic [sobel_pkg::OUT_COL_BITS-1:0]          out_column,
	output logic                                        frame_last,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [sobel_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [sobel_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int WCAP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
	localparam logic [sobel_pkg::COL_BITS-1:0] W_CAP = sobel_pkg::COL_BITS'(WCAP);
	localparam logic [sobel_pkg::HGT_BITS-1:0] H_CAP =
		sobel_pkg::HGT_BITS'(sobel_pkg::MAX_HEIGHT);

	logic [sobel_pkg::COL_BITS-1:0] width_q;
	logic [sobel_pkg::HGT_BITS-1:0] height_q;
	sobel_pkg::frame_cfg_t          eff_cfg;

	logic               q_push, q_full, q_pop, q_empty;
	sobel_pkg::q_item_t q_in, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sobel_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[sobel_pkg::COL_BITS-1:0];
				end
				sobel_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (width_q < 12'd3) begin
			eff_cfg.width = 12'd3;
		end else if (width_q > W_CAP) begin
			eff_cfg.width = W_CAP;
		end else begin
			eff_cfg.width = width_q;
		end
		if (height_q < 13'd3) begin
			eff_cfg.height = 13'd3;
		end else if (height_q > H_CAP) begin
			eff_cfg.height = H_CAP;
		end else begin
			eff_cfg.height = height_q;
		end
	end

	sobel_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (eff_cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.frame_start(frame_start),
		.q_push     (q_push),
		.q_data     (q_in),
		.q_full     (q_full)
	);

	sobel_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	sobel_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.out_row   (out_row),
		.out_column(out_column),
		.frame_last(frame_last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("window queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("window queue popped while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled with room in the queue");

	a_pop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || !out_stall))
		else $error("queue drained while result pipeline held");

endmodule
`default_nettype wire

// ===== hw/rtl/sobel_front.sv =====
// Front end: frame counters, line store, 3x3 window and interior classification.
`default_nettype none
module sobel_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sobel_pkg::frame_cfg_t             cfg,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sobel_pkg::PIXEL_BITS-1:0]  pixel,
	input  wire logic                              frame_start,
	output logic                                   q_push,
	output sobel_pkg::q_item_t                     q_data,
	input  wire logic                              q_full
);

	localparam int PB = sobel_pkg::PIXEL_BITS;
	localparam int CB = sobel_pkg::COL_BITS;
	localparam int RB = sobel_pkg::ROW_BITS;
	localparam int HB = sobel_pkg::HGT_BITS;
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef logic [2*PB-1:0] entry_t;

	// entry: upper row in the high half, middle row in the low half
	entry_t mem [MAX_WIDTH];

	logic [CB-1:0] col_q, c0, c_cur, c_inc, col_nxt;
	logic [RB-1:0] row_q, r_cur, row_nxt;
	logic [HB-1:0] r0, r_inc;

	logic                s1_valid;
	sobel_pkg::pix_t     px_s1;
	logic [CB-1:0]       c_s1;
	logic [RB-1:0]       r_s1;
	logic                int_s1;
	logic                last_s1;

	entry_t              rd_q, fwd_data_q, rd_eff;
	logic                fwd_q;
	sobel_pkg::win_t     win_q, win_nxt;

	logic accept, retire;

	assign retire   = s1_valid && (!int_s1 || !q_full);
	assign in_stall = s1_valid && !retire;
	assign accept   = in_valid && !in_stall;
	assign q_push   = retire && int_s1;
	assign rd_eff   = fwd_q ? fwd_data_q : rd_q;

	always_comb begin
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : {1'b0, row_q};
		if (c0 >= cfg.width) begin
			c0 = '0;
			r0 = r0 + 13'd1;
		end
		if (r0 >= cfg.height) begin
			r0 = '0;
		end
		c_cur = c0;
		r_cur = r0[RB-1:0];
		c_inc = c_cur + 12'd1;
		r_inc = {1'b0, r_cur} + 13'd1;
		if (c_inc >= cfg.width) begin
			col_nxt = '0;
			row_nxt = (r_inc >= cfg.height) ? '0 : r_inc[RB-1:0];
		end else begin
			col_nxt = c_inc;
			row_nxt = r_cur;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nxt[k*3]     = win_q[k*3+1];
			win_nxt[k*3 + 1] = win_q[k*3+2];
		end
		win_nxt[2] = rd_eff[2*PB-1:PB];
		win_nxt[5] = rd_eff[PB-1:0];
		win_nxt[8] = px_s1;
	end

	always_comb begin
		q_data.win      = win_nxt;
		q_data.tag.row  = r_s1 - 12'd1;
		q_data.tag.col  = sobel_pkg::OUT_COL_BITS'(c_s1 - 12'd1);
		q_data.tag.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
			fwd_q    <= 1'b0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				col_q    <= col_nxt;
				row_q    <= row_nxt;
				s1_valid <= 1'b1;
				fwd_q    <= retire && (c_cur == c_s1);
			end else if (retire) begin
				s1_valid <= 1'b0;
			end
			if (retire) begin
				win_q <= win_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pixel;
			c_s1       <= c_cur;
			r_s1       <= r_cur;
			int_s1     <= (r_cur >= 12'd2) && (c_cur >= 12'd2);
			last_s1    <= ({1'b0, r_cur} == cfg.height - 13'd1) && (c_cur == cfg.width - 12'd1);
			rd_q       <= mem[AW'(c_cur)];
			fwd_data_q <= {rd_eff[PB-1:0], px_s1};
		end
		if (retire) begin
			mem[AW'(c_s1)] <= {rd_eff[PB-1:0], px_s1};
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sobel_queue.sv =====
// Short FIFO of classified windows between the front end and the gradient pipeline.
`default_nettype none
module sobel_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sobel_pkg::q_item_t  push_data,
	output logic                     full,
	input  wire logic                pop,
	output sobel_pkg::q_item_t       head,
	output logic                     empty
);

	localparam int DEPTH = sobel_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	sobel_pkg::q_item_t slots [DEPTH];
	logic [PW-1:0]      wr_q, rd_q;
	logic [PW:0]        count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sobel_back.sv =====
// Back end: gradients, squares, sum and a pipelined integer square root.
`default_nettype none
module sobel_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire sobel_pkg::q_item_t                  q_head,
	output logic                                     q_pop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sobel_pkg::ROOT_BITS-1:0]          magnitude,
	output logic [sobel_pkg::ROW_BITS-1:0]           out_row,
	output logic [sobel_pkg::OUT_COL_BITS-1:0]       out_column,
	output logic                                     frame_last
);

	localparam int GB  = sobel_pkg::GRAD_BITS;
	localparam int SB  = sobel_pkg::SQ_BITS;
	localparam int RTB = sobel_pkg::ROOT_BITS;
	localparam int RDB = sobel_pkg::RAD_BITS;

	logic adv;
	logic [GB-1:0] gx_pos, gx_neg, gy_pos, gy_neg, ax, ay;
	sobel_pkg::win_t w;

	logic                vld_s1, vld_s2;
	logic [GB-1:0]       ax_s1, ay_s1;
	sobel_pkg::tag_t     tag_s1, tag_s2;
	logic [SB-1:0]       sqx_s2, sqy_s2;

	logic                vld_s  [RTB+1];
	logic [RDB-1:0]      rad_s  [RTB+1];
	logic [RTB:0]        rem_s  [RTB+1];
	logic [RTB-1:0]      root_s [RTB+1];
	sobel_pkg::tag_t     tag_s  [RTB+1];

	assign adv   = !out_valid || !out_stall;
	assign q_pop = adv && !q_empty;
	assign w     = q_head.win;

	always_comb begin
		gx_pos = GB'(w[2]) + {1'b0, w[5], 1'b0} + GB'(w[8]);
		gx_neg = GB'(w[0]) + {1'b0, w[3], 1'b0} + GB'(w[6]);
		gy_pos = GB'(w[6]) + {1'b0, w[7], 1'b0} + GB'(w[8]);
		gy_neg = GB'(w[0]) + {1'b0, w[1], 1'b0} + GB'(w[2]);
		ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
		ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1   <= !q_empty;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1     <= ax;
			ay_s1     <= ay;
			tag_s1    <= q_head.tag;
			sqx_s2    <= ax_s1 * ax_s1;
			sqy_s2    <= ay_s1 * ay_s1;
			tag_s2    <= tag_s1;
			rad_s[0]  <= RDB'({1'b0, sqx_s2} + {1'b0, sqy_s2});
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			tag_s[0]  <= tag_s2;
		end
	end

	for (genvar i = 1; i <= RTB; i++) begin : g_step
		logic [RTB+2:0] r2;
		logic [RTB+1:0] t;
		logic           ge;

		always_comb begin
			r2 = {rem_s[i-1], rad_s[i-1][RDB-1 -: 2]};
			t  = {root_s[i-1], 2'b01};
			ge = (r2 >= {1'b0, t});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[i] <= rad_s[i-1] << 2;
				tag_s[i] <= tag_s[i-1];
				if (ge) begin
					rem_s[i]  <= (RTB+1)'(r2 - {1'b0, t});
					root_s[i] <= {root_s[i-1][RTB-2:0], 1'b1};
				end else begin
					rem_s[i]  <= (RTB+1)'(r2);
					root_s[i] <= {root_s[i-1][RTB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid  = vld_s[RTB];
	assign magnitude  = root_s[RTB];
	assign out_row    = tag_s[RTB].row;
	assign out_column = tag_s[RTB].col;
	assign frame_last = tag_s[RTB].last;

endmodule
`default_nettype wire

// ===== verif/edge_magnitude_checker.sv =====
// Checker for the Sobel core: predicts each edge result and compares it with the output channel.
module edge_magnitude_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [sobel_pkg::PIXEL_BITS-1:0]     pixel,
	input  logic                                 frame_start,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [sobel_pkg::ROOT_BITS-1:0]      magnitude,
	input  logic [sobel_pkg::ROW_BITS-1:0]       out_row,
	input  logic [sobel_pkg::OUT_COL_BITS-1:0]   out_column,
	input  logic                                 frame_last,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [sobel_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sobel_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                   mismatch_count,
	output int                                   pending_edges,
	output int                                   pixels_accepted,
	output int                                   edges_checked
);

	typedef struct packed {
		logic [sobel_pkg::ROOT_BITS-1:0]    magnitude;
		logic [sobel_pkg::ROW_BITS-1:0]     row;
		logic [sobel_pkg::OUT_COL_BITS-1:0] column;
		logic                               last;
	} edge_result_t;

	edge_result_t expected_edges[$];

	logic [sobel_pkg::COL_BITS-1:0] width_reg;
	logic [sobel_pkg::HGT_BITS-1:0] height_reg;
	sobel_pkg::pix_t upper_line[MAX_WIDTH];
	sobel_pkg::pix_t middle_line[MAX_WIDTH];
	sobel_pkg::pix_t window_px[9];
	int unsigned col_pos;
	int unsigned row_pos;

	function automatic logic [sobel_pkg::ROOT_BITS-1:0] floor_sqrt(input int unsigned v);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = sobel_pkg::ROOT_BITS - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[sobel_pkg::ROOT_BITS-1:0];
	endfunction

	// one pixel through the line stores and window; queues a result for interior centres
	task automatic predict_edge(input sobel_pkg::pix_t px, input logic fs);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int gx;
		int gy;
		edge_result_t res;
		w = 32'(width_reg);
		if (w < 3) w = 3;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = 32'(height_reg);
		if (h < 3) h = 3;
		if (h > sobel_pkg::MAX_HEIGHT) h = sobel_pkg::MAX_HEIGHT;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		c = col_pos;
		r = row_pos;
		for (int k = 0; k < 3; k++) begin
			window_px[k*3]   = window_px[k*3+1];
			window_px[k*3+1] = window_px[k*3+2];
		end
		window_px[2] = upper_line[c];
		window_px[5] = middle_line[c];
		window_px[8] = px;
		upper_line[c] = middle_line[c];
		middle_line[c] = px;
		if (r >= 2 && c >= 2) begin
			gx = int'(window_px[2]) + 2 * int'(window_px[5]) + int'(window_px[8])
				- int'(window_px[0]) - 2 * int'(window_px[3]) - int'(window_px[6]);
			gy = int'(window_px[6]) + 2 * int'(window_px[7]) + int'(window_px[8])
				- int'(window_px[0]) - 2 * int'(window_px[1]) - int'(window_px[2]);
			res.magnitude = floor_sqrt(unsigned'(gx * gx + gy * gy));
			res.row       = sobel_pkg::ROW_BITS'(r - 1);
			res.column    = sobel_pkg::OUT_COL_BITS'(c - 1);
			res.last      = (r == h - 1) && (c == w - 1);
			expected_edges.push_back(res);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	function automatic void check_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_edge();
		edge_result_t want;
		if (expected_edges.size() == 0) begin
			$error("unexpected request: magnitude %0d row %0d column %0d last %0b",
				magnitude, out_row, out_column, frame_last);
			mismatch_count++;
		end else begin
			want = expected_edges.pop_front();
			edges_checked++;
			check_field("magnitude", 12'(want.magnitude), 12'(magnitude));
			check_field("out_row", want.row, out_row);
			check_field("out_column", 12'(want.column), 12'(out_column));
			check_field("frame_last", 12'(want.last), 12'(frame_last));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			width_reg = sobel_pkg::WIDTH_RESET;
			height_reg = sobel_pkg::HEIGHT_RESET;
			col_pos = 0;
			row_pos = 0;
			foreach (window_px[k]) window_px[k] = '0;
			foreach (upper_line[k]) begin
				upper_line[k] = '0;
				middle_line[k] = '0;
			end
			expected_edges.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sobel_pkg::REG_IMAGE_WIDTH:
						width_reg = cfg_data[sobel_pkg::COL_BITS-1:0];
					sobel_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				pixels_accepted++;
				predict_edge(pixel, frame_start);
			end
			if (out_valid && !out_stall)
				check_edge();
		end
		pending_edges = expected_edges.size();
	end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the Sobel edge magnitude core: reset, stimulus, pacing and verdict.
module testbench;

	localparam int LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_ITEMS = 1050;
	localparam logic [sobel_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [sobel_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

	// gradient probes: diagonal edge, overrun with bright left side, short restart, flat checker
	localparam sobel_pkg::pix_t PROBE_PIXELS [29] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255,
		8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,
		8'd255, 8'd0,
		8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sobel_pkg::pix_t pixel = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sobel_pkg::ROOT_BITS-1:0] magnitude;
	logic [sobel_pkg::ROW_BITS-1:0] out_row;
	logic [sobel_pkg::OUT_COL_BITS-1:0] out_column;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sobel_pkg::CFG_INDEX_BITS-1:0] cfg_index = sobel_pkg::REG_IMAGE_WIDTH;
	logic [sobel_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	int mismatch_count;
	int pending_edges;
	int pixels_accepted;
	int edges_checked;

	int unsigned sender_pct = 0;
	int unsigned receiver_pct = 0;
	bit rx_hold = 1'b0;
	bit rx_held = 1'b0;
	int unsigned frame_w = 0;
	int unsigned frame_h = 3;
	int unsigned frame_pos = 0;
	int small_items = 0;
	int settings_count = 0;
	int unsigned cycle_count = 0;

	sobel_edge_magnitude_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .magnitude(magnitude),
		.out_row(out_row), .out_column(out_column), .frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	edge_magnitude_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall), .magnitude(magnitude),
		.out_row(out_row), .out_column(out_column), .frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .pending_edges(pending_edges),
		.pixels_accepted(pixels_accepted), .edges_checked(edges_checked)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("sobel_edge_magnitude_core regression: fail");
			$finish;
		end
	end

	// output side: random stall, or one long hold-off while the sender keeps pushing
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold && !rx_held) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_held = 1'b1;
			end
			if (!rx_hold)
				rx_held = 1'b0;
			out_stall = $urandom_range(99) < receiver_pct;
		end
	end

	function automatic sobel_pkg::pix_t next_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 8'd128;
			default: return sobel_pkg::pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(input sobel_pkg::pix_t px, input logic fs);
		while ($urandom_range(99) < sender_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel = px;
		frame_start = fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [sobel_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [sobel_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_edges != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// a wider frame must start with frame_start so no unwritten line store entry is read
	task automatic apply_frame(input logic [sobel_pkg::CFG_DATA_BITS-1:0] w_data,
			input logic [sobel_pkg::CFG_DATA_BITS-1:0] h_data, output bit fresh);
		int unsigned new_w;
		int unsigned new_h;
		new_w = 32'(w_data[sobel_pkg::COL_BITS-1:0]);
		if (new_w < 3) new_w = 3;
		if (new_w > 2048) new_w = 2048;
		new_h = 32'(h_data);
		if (new_h < 3) new_h = 3;
		if (new_h > sobel_pkg::MAX_HEIGHT) new_h = sobel_pkg::MAX_HEIGHT;
		fresh = new_w > frame_w;
		wait_idle();
		cfg_write(sobel_pkg::REG_IMAGE_HEIGHT, h_data);
		cfg_write(sobel_pkg::REG_IMAGE_WIDTH, w_data);
		cfg_valid = 1'b0;
		frame_w = new_w;
		frame_h = new_h;
		settings_count++;
	endtask

	task automatic stream_pixels(input int n, input bit fresh, input bit noisy);
		logic fs;
		for (int i = 0; i < n; i++) begin
			fs = 1'b0;
			if (i == 0 && fresh)
				fs = 1'b1;
			else if (frame_pos == 0)
				fs = $urandom_range(9) != 0;
			else if (noisy && $urandom_range(199) == 0)
				fs = 1'b1;
			if (fs)
				frame_pos = 0;
			send_pixel(next_pixel(), fs);
			frame_pos++;
			if (frame_pos >= frame_w * frame_h)
				frame_pos = 0;
		end
		in_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [sobel_pkg::CFG_DATA_BITS-1:0] w_data,
			input logic [sobel_pkg::CFG_DATA_BITS-1:0] h_data, input pace_t pace, input int n,
			input bit noisy, input bit hold);
		bit fresh;
		apply_frame(w_data, h_data, fresh);
		sender_pct = (pace == PACE_SENDER_IDLE) ? 83 : (pace == PACE_BOTH) ? 31 : 0;
		receiver_pct = (pace == PACE_RECEIVER_STALL) ? 83 : (pace == PACE_BOTH) ? 31 : 0;
		rx_hold = hold;
		stream_pixels(n, fresh, noisy);
		rx_hold = 1'b0;
		if (noisy)
			small_items += n;
	endtask

	initial begin
		bit fresh;
		logic [sobel_pkg::CFG_DATA_BITS-1:0] w_data;
		logic [sobel_pkg::CFG_DATA_BITS-1:0] h_data;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		cfg_write(REG_SPARE_2, 13'h1FFF);
		cfg_write(REG_SPARE_3, 13'h0AAA);
		cfg_valid = 1'b0;
		apply_frame(13'd3, 13'd3, fresh);
		for (int i = 0; i < 29; i++)
			send_pixel(PROBE_PIXELS[i], i == 0 || i == 18 || i == 20);
		in_valid = 1'b0;
		frame_pos = 0;

		run_phase(13'h1005, 13'd4, PACE_FREE, 150, 1'b1, 1'b0);
		run_phase(13'd0, 13'd0, PACE_SENDER_IDLE, 100, 1'b1, 1'b0);
		run_phase(13'd8, 13'd6, PACE_RECEIVER_STALL, 150, 1'b1, 1'b0);
		run_phase(13'd6, 13'd5, PACE_BOTH, 150, 1'b1, 1'b0);
		run_phase(13'd7, 13'd5, PACE_FREE, 150, 1'b1, 1'b1);
		run_phase(13'd2048, 13'd3, PACE_FREE, 40, 1'b0, 1'b0);
		run_phase(13'd3, 13'd4096, PACE_FREE, 60, 1'b0, 1'b0);
		run_phase(13'd4095, 13'd2, PACE_BOTH, 80, 1'b1, 1'b0);
		run_phase(13'd5, 13'd8191, PACE_SENDER_IDLE, 120, 1'b1, 1'b0);
		run_phase(13'd1, 13'd2, PACE_RECEIVER_STALL, 100, 1'b1, 1'b0);

		while (small_items < RANDOM_ITEMS) begin
			w_data = sobel_pkg::CFG_DATA_BITS'(($urandom_range(15) == 0) ? $urandom_range(2) :
				($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(3, 12));
			h_data = sobel_pkg::CFG_DATA_BITS'(($urandom_range(15) == 0) ?
				$urandom_range(2) : $urandom_range(3, 9));
			run_phase(w_data, h_data, pace_t'($urandom_range(3)), $urandom_range(60, 160),
				1'b1, 1'b0);
		end

		wait_idle();
		$display("covered %0d pixels and %0d checked edge requests over %0d frame settings",
			pixels_accepted, edges_checked, settings_count);
		$display("sizes from 3x3 to 2048 wide and 4096 high, with restarts, overruns and stalls");
		if (mismatch_count == 0)
			$display("sobel_edge_magnitude_core regression: pass");
		else
			$display("sobel_edge_magnitude_core regression: fail");
		$finish;
	end

endmodule
